/* rtl/core/fifo_queue_with_search_defines.svh */
// Assertion macros used by the queue's top-level RTL file.
`ifndef FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FQS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fifo_queue_with_search: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fifo_queue_with_search: next-cycle check failed");

`endif

/* rtl/core/fqs_pkg.sv */
// Types, codes and constants shared by the queue controller, datapath and top level.
`timescale 1ns / 1ps
package fqs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int MATCH_W   = 5;
    localparam logic [MATCH_W-1:0] MATCH_MAX = '1;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_LIST   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DEQ_OUT,
        S_SRCH,
        S_SRCH_END,
        S_SRCH_OUT,
        S_LIST_RD,
        S_LIST_PUSH
    } t_state;

    typedef enum logic [2:0] {
        PUSH_NONE,
        PUSH_FULL,
        PUSH_EMPTY,
        PUSH_ENQ_OK,
        PUSH_DEQ,
        PUSH_SEARCH,
        PUSH_LIST
    } t_push;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  enq_write;
        logic  empty_reset;
        logic  deq_rd;
        logic  deq_pop;
        logic  walk_init;
        logic  walk_rd;
        t_push push;
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
        logic walk_last;
        logic list_last;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/core/fqs_ctrl.sv */
// Controller state machine that sequences each queue transaction.
`timescale 1ns / 1ps
module fqs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  fqs_pkg::t_dp_stat  i_stat,
    output fqs_pkg::t_dp_ctrl  o_ctrl
);

    fqs_pkg::t_state r_state;
    fqs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fqs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_ctrl.push = fqs_pkg::PUSH_NONE;
        o_stall = (r_state != fqs_pkg::S_IDLE);
        unique case (r_state)
            fqs_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = fqs_pkg::S_DISPATCH;
                end
            end
            fqs_pkg::S_DISPATCH: begin
                unique case (i_stat.cmd)
                    fqs_pkg::CMD_ENQ: begin
                        if (i_stat.out_free) begin
                            if (i_stat.full) begin
                                o_ctrl.push = fqs_pkg::PUSH_FULL;
                            end else begin
                                o_ctrl.enq_write = 1'b1;
                                o_ctrl.push      = fqs_pkg::PUSH_ENQ_OK;
                            end
                            n_state = fqs_pkg::S_IDLE;
                        end
                    end
                    fqs_pkg::CMD_DEQ: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_ctrl.empty_reset = 1'b1;
                                o_ctrl.push        = fqs_pkg::PUSH_EMPTY;
                                n_state            = fqs_pkg::S_IDLE;
                            end
                        end else begin
                            o_ctrl.deq_rd = 1'b1;
                            n_state       = fqs_pkg::S_DEQ_OUT;
                        end
                    end
                    fqs_pkg::CMD_SEARCH, fqs_pkg::CMD_LIST: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_ctrl.push = fqs_pkg::PUSH_EMPTY;
                                n_state     = fqs_pkg::S_IDLE;
                            end
                        end else begin
                            o_ctrl.walk_init = 1'b1;
                            n_state = (i_stat.cmd == fqs_pkg::CMD_SEARCH) ?
                                      fqs_pkg::S_SRCH : fqs_pkg::S_LIST_RD;
                        end
                    end
                    default: n_state = fqs_pkg::S_IDLE;
                endcase
            end
            fqs_pkg::S_DEQ_OUT: begin
                if (i_stat.out_free) begin
                    o_ctrl.push    = fqs_pkg::PUSH_DEQ;
                    o_ctrl.deq_pop = 1'b1;
                    n_state        = fqs_pkg::S_IDLE;
                end
            end
            fqs_pkg::S_SRCH: begin
                o_ctrl.walk_rd = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = fqs_pkg::S_SRCH_END;
                end
            end
            fqs_pkg::S_SRCH_END: begin
                n_state = fqs_pkg::S_SRCH_OUT;
            end
            fqs_pkg::S_SRCH_OUT: begin
                if (i_stat.out_free) begin
                    o_ctrl.push = fqs_pkg::PUSH_SEARCH;
                    n_state     = fqs_pkg::S_IDLE;
                end
            end
            fqs_pkg::S_LIST_RD: begin
                o_ctrl.walk_rd = 1'b1;
                n_state        = fqs_pkg::S_LIST_PUSH;
            end
            fqs_pkg::S_LIST_PUSH: begin
                if (i_stat.out_free) begin
                    o_ctrl.push = fqs_pkg::PUSH_LIST;
                    if (i_stat.list_last) begin
                        n_state = fqs_pkg::S_IDLE;
                    end else begin
                        o_ctrl.walk_rd = 1'b1;
                    end
                end
            end
            default: n_state = fqs_pkg::S_IDLE;
        endcase
    end

endmodule

/* rtl/core/fqs_dp.sv */
// Datapath of the queue: entry memory, pointers, walk counters and output register.
`timescale 1ns / 1ps
module fqs_dp #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [1:0]                          i_command,
    input  logic signed [fqs_pkg::DATA_W-1:0]   i_value,
    input  fqs_pkg::t_dp_ctrl                   i_ctrl,
    output fqs_pkg::t_dp_stat                   o_stat,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic signed [fqs_pkg::DATA_W-1:0]   o_item_value,
    output logic                                o_found,
    output logic [fqs_pkg::MATCH_W-1:0]         o_match_count,
    output logic                                o_last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_OCC  = CW'(DEPTH);

    logic [fqs_pkg::DATA_W-1:0] mem [DEPTH];

    fqs_pkg::t_cmd               r_cmd;
    logic [fqs_pkg::DATA_W-1:0]  r_value;
    logic [IW-1:0]               r_head;
    logic [IW-1:0]               r_tail;
    logic [CW-1:0]               r_occ;
    logic [IW-1:0]               r_slot;
    logic [CW-1:0]               r_cnt;
    logic [fqs_pkg::MATCH_W-1:0] r_match;
    logic [fqs_pkg::DATA_W-1:0]  r_rd_data;
    logic                        r_rd_vld;
    logic                        r_out_valid;
    logic [1:0]                  r_out_status;
    logic [fqs_pkg::DATA_W-1:0]  r_out_item;
    logic                        r_out_found;
    logic [fqs_pkg::MATCH_W-1:0] r_out_match;
    logic                        r_out_last;

    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    logic                        out_free;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : IW'(s + 1'b1);
    endfunction

    assign rd_en    = i_ctrl.deq_rd | i_ctrl.walk_rd;
    assign rd_addr  = i_ctrl.deq_rd ? r_head : r_slot;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.empty     = (r_occ == '0);
        o_stat.full      = (r_occ >= FULL_OCC);
        o_stat.walk_last = (CW'(r_cnt + 1'b1) == r_occ);
        o_stat.list_last = (r_cnt == r_occ);
        o_stat.out_free  = out_free;
    end

    // Entry memory: one write port at the tail, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.enq_write) begin
            mem[r_tail] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Transaction payload, held for the whole transaction.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_value <= i_value;
        end
    end

    // Queue pointers, occupancy and walk state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd    <= fqs_pkg::CMD_ENQ;
            r_head   <= '0;
            r_tail   <= '0;
            r_occ    <= '0;
            r_slot   <= '0;
            r_cnt    <= '0;
            r_match  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (i_ctrl.load) begin
                r_cmd <= fqs_pkg::t_cmd'(i_command);
            end
            if (i_ctrl.enq_write) begin
                r_tail <= next_slot(r_tail);
                r_occ  <= CW'(r_occ + 1'b1);
            end
            if (i_ctrl.empty_reset) begin
                r_head <= '0;
                r_tail <= '0;
            end
            if (i_ctrl.deq_pop) begin
                r_occ <= CW'(r_occ - 1'b1);
                if (r_occ == CW'(1)) begin
                    r_head <= '0;
                    r_tail <= '0;
                end else begin
                    r_head <= next_slot(r_head);
                end
            end
            if (i_ctrl.walk_init) begin
                r_slot  <= r_head;
                r_cnt   <= '0;
                r_match <= '0;
            end
            if (i_ctrl.walk_rd) begin
                r_slot <= next_slot(r_slot);
                r_cnt  <= CW'(r_cnt + 1'b1);
            end
            if (r_rd_vld && r_cmd == fqs_pkg::CMD_SEARCH && r_rd_data == r_value &&
                r_match != fqs_pkg::MATCH_MAX) begin
                r_match <= r_match + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.push != fqs_pkg::PUSH_NONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push != fqs_pkg::PUSH_NONE) begin
            r_out_status <= fqs_pkg::STAT_OK;
            r_out_item   <= '0;
            r_out_found  <= 1'b0;
            r_out_match  <= '0;
            r_out_last   <= 1'b1;
            unique case (i_ctrl.push)
                fqs_pkg::PUSH_FULL:   r_out_status <= fqs_pkg::STAT_FULL;
                fqs_pkg::PUSH_EMPTY:  r_out_status <= fqs_pkg::STAT_EMPTY;
                fqs_pkg::PUSH_DEQ:    r_out_item   <= r_rd_data;
                fqs_pkg::PUSH_SEARCH: begin
                    r_out_found <= (r_match != '0);
                    r_out_match <= r_match;
                end
                fqs_pkg::PUSH_LIST: begin
                    r_out_item <= r_rd_data;
                    r_out_last <= (r_cnt == r_occ);
                end
                default: r_out_status <= fqs_pkg::STAT_OK;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_item_value  = r_out_item;
    assign o_found       = r_out_found;
    assign o_match_count = r_out_match;
    assign o_last        = r_out_last;

endmodule

/* rtl/core/fifo_queue_with_search.sv */
// Top level of the FIFO queue with search: controller, datapath and checks.
`timescale 1ns / 1ps
// This block is a first-in first-out queue of DEPTH signed 32-bit entries that
// takes one command per input transaction: enqueue, dequeue, search or list.
// Transactions are taken one at a time; the input stall is low only while the
// controller is idle, and a finished result waits in an output register, so
// the next transaction can be accepted while the previous result is still
// being held off by the downstream stall. Dequeue reads its entry through the
// single registered read port of the entry memory. Search and list walk the
// stored entries through that read port one entry per cycle, list only while
// the output is not stalled. List produces one result transaction per entry,
// with the last flag set on the final one. The entry memory needs no clearing
// after reset, since only occupied slots are ever read.
`include "fifo_queue_with_search_defines.svh"
module fifo_queue_with_search #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_command,
    input  logic signed [fqs_pkg::DATA_W-1:0]   i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic signed [fqs_pkg::DATA_W-1:0]   o_item_value,
    output logic                                o_found,
    output logic [fqs_pkg::MATCH_W-1:0]         o_match_count,
    output logic                                o_last
);

    // Commands from the controller and status back from the datapath.
    fqs_pkg::t_dp_ctrl w_ctrl;
    fqs_pkg::t_dp_stat w_stat;

    fqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    fqs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_item_value  (o_item_value),
        .o_found       (o_found),
        .o_match_count (o_match_count),
        .o_last        (o_last)
    );

    // Once a transaction is taken, the block is busy in the following cycle.
    `FQS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // The controller only loads the output register when it is free.
    `FQS_ASSERT_NOW(a_push_when_free, i_clk, i_rst_n, w_ctrl.push != fqs_pkg::PUSH_NONE, w_stat.out_free)
    // A full queue is never also reported as empty.
    `FQS_ASSERT_NOW(a_full_not_empty, i_clk, i_rst_n, w_stat.full, !w_stat.empty)
    // A dropped enqueue gives a single, data-free result.
    `FQS_ASSERT_NOW(a_full_result, i_clk, i_rst_n, o_valid && o_status == fqs_pkg::STAT_FULL, o_last && o_item_value == '0 && !o_found)

endmodule
